@@ rtl/core/ttrc_pkg.sv @@
// Constants and modular helpers for the three-term recurrence checksum.
package ttrc_pkg;

  localparam int unsigned TermWidth  = 16;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned ProdWidth  = 25;

  localparam logic [TermWidth-1:0] Modulus   = 16'hFFFF;
  localparam logic [TermWidth-1:0] TermReset = 16'd1;
  localparam logic [ByteWidth-1:0] FirstOffset = 8'd7;
  localparam logic [ByteWidth-1:0] AlphaCoef = 8'd17;
  localparam logic [ByteWidth-1:0] BetaCoef  = 8'd31;

  typedef enum logic {
    ACT_BYTE   = 1'b0,
    ACT_FINISH = 1'b1
  } action_t;

  // Reduce a product modulo 2^16-1 by folding the high bits onto the low bits.
  function automatic logic [TermWidth-1:0] mod_fold(input logic [ProdWidth-1:0] x);
    logic [TermWidth:0] s;
    logic [TermWidth:0] u;
    s = {8'd0, x[ProdWidth-1:TermWidth]} + {1'b0, x[TermWidth-1:0]};
    u = {16'd0, s[TermWidth]} + {1'b0, s[TermWidth-1:0]};
    if (u[TermWidth-1:0] == Modulus) begin
      mod_fold = '0;
    end else begin
      mod_fold = u[TermWidth-1:0];
    end
  endfunction

endpackage

@@ rtl/core/three_term_recurrence_checksum.sv @@
// Top level of the three-term recurrence checksum over a byte stream.
//
// Input channel s_*: one word per message byte (s_tuser = 0) or a finish
// word (s_tuser = 1) that closes the message. Output channel m_*: one
// checksum word per finish word, nothing for byte words.
// Each byte word updates the recurrence terms in the same cycle it is
// accepted: two narrow multiplies, two folds modulo 65535 and a subtract sit
// between the term registers, so a word is taken every cycle while s_tready is high.
// A finish word loads the newest term into the output register; the
// checksum shows on m_tdata in the cycle after the finish word is accepted,
// and the terms return to their reset values at the same edge.
// Throughput: one word per cycle while s_tready is high, set by the combinational term update.
// When the receiver stalls with a checksum pending, s_tready drops until
// the checksum is taken; the output register frees in the cycle it is
// read, so no bubble appears while m_tready stays high.
// Reset (rst, synchronous, active high) clears the terms to 1, the byte
// position to 0 and drops m_tvalid.
module three_term_recurrence_checksum (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [15:0] checksum
);

  localparam int unsigned TW = ttrc_pkg::TermWidth;
  localparam int unsigned BW = ttrc_pkg::ByteWidth;
  localparam int unsigned PW = ttrc_pkg::ProdWidth;

  logic [TW-1:0] older_term;
  logic [TW-1:0] newer_term;
  logic [BW-1:0] byte_position;
  logic          seen_first;

  logic [TW-1:0] older_term_next;
  logic [TW-1:0] newer_term_next;
  logic [BW-1:0] byte_position_next;
  logic          seen_first_next;

  logic          in_fire;
  logic          is_finish;
  logic [BW-1:0] alpha;
  logic [BW-1:0] beta;
  logic [BW:0]   factor_a;
  logic [PW-1:0] prod_a;
  logic [PW-1:0] prod_b;
  logic [TW-1:0] mod_a;
  logic [TW-1:0] mod_b;
  logic          a_below_b;
  logic [TW+1:0] diff;
  logic [TW-1:0] term_new;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;
  assign is_finish = (s_tuser == ttrc_pkg::ACT_FINISH);

  assign alpha    = BW'(byte_position * ttrc_pkg::AlphaCoef);
  assign beta     = BW'(byte_position * ttrc_pkg::BetaCoef);
  assign factor_a = {1'b0, s_tdata} + {1'b0, alpha};
  assign prod_a   = {{(PW-BW-1){1'b0}}, factor_a} * {{(PW-TW){1'b0}}, newer_term};
  assign prod_b   = {{(PW-BW){1'b0}}, beta} * {{(PW-TW){1'b0}}, older_term};
  assign mod_a    = ttrc_pkg::mod_fold(prod_a);
  assign mod_b    = ttrc_pkg::mod_fold(prod_b);
  assign a_below_b = prod_a < prod_b;

  // A wrapped 18-bit difference adds one modulo 65535.
  always_comb begin
    diff = {2'b00, mod_a} - {2'b00, mod_b} + {{(TW+1){1'b0}}, a_below_b};
    if (diff[TW+1]) begin
      term_new = TW'(diff + {2'b00, ttrc_pkg::Modulus});
    end else if (diff[TW:0] >= {1'b0, ttrc_pkg::Modulus}) begin
      term_new = TW'(diff - {2'b00, ttrc_pkg::Modulus});
    end else begin
      term_new = diff[TW-1:0];
    end
  end

  always_comb begin
    older_term_next    = older_term;
    newer_term_next    = newer_term;
    byte_position_next = byte_position;
    seen_first_next    = seen_first;
    if (in_fire) begin
      if (is_finish) begin
        older_term_next    = ttrc_pkg::TermReset;
        newer_term_next    = ttrc_pkg::TermReset;
        byte_position_next = '0;
        seen_first_next    = 1'b0;
      end else begin
        if (!seen_first) begin
          older_term_next = ttrc_pkg::TermReset;
          newer_term_next = TW'(s_tdata) + TW'(ttrc_pkg::FirstOffset);
          seen_first_next = 1'b1;
        end else begin
          older_term_next = newer_term;
          newer_term_next = term_new;
        end
        byte_position_next = byte_position + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_term    <= ttrc_pkg::TermReset;
      newer_term    <= ttrc_pkg::TermReset;
      byte_position <= '0;
      seen_first    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      older_term    <= older_term_next;
      newer_term    <= newer_term_next;
      byte_position <= byte_position_next;
      seen_first    <= seen_first_next;
      if (in_fire && is_finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_finish) begin
      m_tdata <= newer_term;
    end
  end

  a_finish_emits: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_finish |=> m_tvalid && (m_tdata == $past(newer_term)))
    else $error("finish word did not emit the newest term");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_finish |=> (newer_term == ttrc_pkg::TermReset) &&
      (older_term == ttrc_pkg::TermReset) && (byte_position == '0) && !seen_first)
    else $error("state not cleared after finish");

  a_idle_terms: assert property (@(posedge clk) disable iff (rst)
    !seen_first |-> (newer_term == ttrc_pkg::TermReset) && (byte_position == '0))
    else $error("terms moved before the first byte");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while checksum pending");

  a_term_range: assert property (@(posedge clk) disable iff (rst)
    seen_first && $past(seen_first) |-> newer_term != ttrc_pkg::Modulus)
    else $error("term out of modular range");

endmodule
